// ===== rtl/lfs_pkg.sv =====
package lfs_pkg;

    // sizes
    localparam int LED_COUNT  = 4;
    localparam int TIME_WIDTH = 16;
    localparam int LED_IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int MASK_LEDS  = (LED_COUNT < 4) ? LED_COUNT : 4;

    // product of a 9-bit unit sum and the 7-bit time scale
    localparam int PROD_W = 16;
    localparam int SAT_W  = PROD_W + TIME_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    // heartbeat LED reset timing in ms
    localparam logic [PROD_W-1:0] HB_ON_MS    = PROD_W'(500);
    localparam logic [PROD_W-1:0] HB_CYCLE_MS = PROD_W'(1000);

    // stream and config port widths
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_ON_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_SCALE      = 2'd1;

    // item kinds
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_SET_CMD = 1'b1;

    // function request codes
    localparam logic [7:0] FN_OFF   = 8'h00;
    localparam logic [7:0] FN_ON    = 8'hFF;
    localparam logic [7:0] FN_LOCAL = 8'hFC;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_IDX = 1'b1;

    // pending change kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ON    = 2'd1;
    localparam logic [1:0] KIND_OFF   = 2'd2;
    localparam logic [1:0] KIND_FLASH = 2'd3;

    // one LED's state record
    typedef struct packed {
        logic [TIME_WIDTH-1:0] on_p;
        logic [TIME_WIDTH-1:0] cyc_p;
        logic [TIME_WIDTH-1:0] pend_on;
        logic [TIME_WIDTH-1:0] pend_cyc;
        logic [1:0]            pend_kind;
        logic [TIME_WIDTH-1:0] ms;
        logic                  ovr;
        logic [1:0]            flashes;
        logic                  lit;
    } lfs_led_t;

    // controller to datapath
    typedef struct packed {
        logic                 load;
        logic                 apply_cmd;
        logic                 step;
        logic [LED_IDX_W-1:0] led;
        logic                 capture;
    } lfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_cmd;
        logic idx_bad;
    } lfs_sts_t;

    function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [PROD_W-1:0] v);
        logic [SAT_W-1:0] ext;
        ext = SAT_W'(v);
        if (ext > SAT_W'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return ext[TIME_WIDTH-1:0];
    endfunction

    // end-of-cycle transition of one LED
    function automatic lfs_led_t next_state(input lfs_led_t r);
        lfs_led_t n;
        n = r;
        if (r.flashes > 2'd1 && r.cyc_p != '0) begin
            n.lit     = 1'b1;
            n.flashes = r.flashes - 2'd1;
        end else if (r.pend_kind != KIND_NONE) begin
            case (r.pend_kind)
                KIND_ON: begin
                    n.lit   = 1'b1;
                    n.cyc_p = '0;
                end
                KIND_OFF: begin
                    n.lit   = 1'b0;
                    n.cyc_p = '0;
                end
                default: begin
                    n.lit   = 1'b1;
                    n.cyc_p = r.pend_cyc;
                    n.on_p  = r.pend_on;
                end
            endcase
            n.pend_kind = KIND_NONE;
        end else if (r.cyc_p != '0) begin
            n.lit = 1'b1;
        end
        return n;
    endfunction

endpackage

// ===== rtl/lfs_ctrl.sv =====
module lfs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  lfs_pkg::lfs_sts_t sts,
    output lfs_pkg::lfs_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_PASS   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [lfs_pkg::LED_IDX_W-1:0] LAST_LED =
        lfs_pkg::LED_IDX_W'(lfs_pkg::LED_COUNT - 1);

    logic [2:0]                    state_reg, state_next;
    logic [lfs_pkg::LED_IDX_W-1:0] cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.led        = cnt_reg;
        s_tready       = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cnt_next = '0;
                if (!sts.is_cmd) begin
                    state_next = ST_PASS;
                end else if (sts.idx_bad) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply_cmd = 1'b1;
                state_next    = ST_PASS;
            end
            ST_PASS: begin
                cmd.step = 1'b1;
                if (cnt_reg == LAST_LED) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/lfs_datapath.sv =====
module lfs_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tuser,
    input  logic [lfs_pkg::S_TDATA_W-1:0]      s_tdata,
    input  lfs_pkg::lfs_cmd_t                  cmd,
    output lfs_pkg::lfs_sts_t                  sts,
    output logic                               m_tuser,
    output logic [lfs_pkg::M_TDATA_W-1:0]      m_tdata
);

    // latched item
    logic       action_reg;
    logic       count_reg;
    logic [7:0] idx_reg;
    logic [7:0] fn_reg;
    logic [7:0] ont_reg;

    // config registers
    logic [3:0] dmask_reg;
    logic [6:0] tscale_reg;

    // per-LED state
    lfs_pkg::lfs_led_t led_reg [lfs_pkg::LED_COUNT];

    logic                          status_reg;
    logic [3:0]                    lit_mask_reg;
    logic [3:0]                    ovr_mask_reg;
    logic [3:0]                    lit_mask_next;
    logic [3:0]                    ovr_mask_next;

    logic [lfs_pkg::LED_IDX_W-1:0] led_addr;
    lfs_pkg::lfs_led_t             rec_cur;
    lfs_pkg::lfs_led_t             cmd_rec;
    lfs_pkg::lfs_led_t             step_rec;
    lfs_pkg::lfs_led_t             rec_next;
    logic [8:0]                    unit_sum;
    logic [lfs_pkg::PROD_W-1:0]    prod_cyc;
    logic [lfs_pkg::PROD_W-1:0]    prod_on;
    logic                          local_on;
    logic                          advance;

    // one pass step over one LED
    function automatic lfs_pkg::lfs_led_t led_step(input lfs_pkg::lfs_led_t r,
                                                   input logic adv);
        lfs_pkg::lfs_led_t n;
        n = r;
        if (r.cyc_p == '0) begin
            n = lfs_pkg::next_state(r);
        end else begin
            if (adv) begin
                n.ms = r.ms + 1'b1;
            end
            if (n.ms >= r.cyc_p) begin
                n.ms = '0;
                n    = lfs_pkg::next_state(n);
            end
            if (n.cyc_p != '0 && n.ms == n.on_p) begin
                n.lit = 1'b0;
            end
        end
        return n;
    endfunction

    // power-up state of one LED
    function automatic lfs_pkg::lfs_led_t led_reset(input int i);
        lfs_pkg::lfs_led_t n;
        n         = '0;
        n.flashes = 2'd1;
        n.lit     = (i == 0);
        // heartbeat LED flashes from reset
        if (i == lfs_pkg::LED_COUNT - 1) begin
            n.on_p  = lfs_pkg::sat_time(lfs_pkg::HB_ON_MS);
            n.cyc_p = lfs_pkg::sat_time(lfs_pkg::HB_CYCLE_MS);
        end
        return n;
    endfunction

    assign sts.is_cmd  = (action_reg == lfs_pkg::ACT_SET_CMD);
    assign sts.idx_bad = (idx_reg >= 8'(lfs_pkg::LED_COUNT));
    assign advance     = (action_reg == lfs_pkg::ACT_TICK) && count_reg;

    assign led_addr = cmd.apply_cmd ? idx_reg[lfs_pkg::LED_IDX_W-1:0] : cmd.led;
    assign rec_cur  = led_reg[led_addr];

    assign unit_sum = {1'b0, fn_reg} + {1'b0, ont_reg};
    assign prod_cyc = lfs_pkg::PROD_W'(unit_sum) * lfs_pkg::PROD_W'(tscale_reg);
    assign prod_on  = lfs_pkg::PROD_W'(ont_reg) * lfs_pkg::PROD_W'(tscale_reg);
    assign local_on = (idx_reg < 8'd4) && dmask_reg[idx_reg[1:0]];

    // set-state command applied to the addressed LED
    always_comb begin
        cmd_rec = rec_cur;
        case (fn_reg)
            lfs_pkg::FN_LOCAL: begin
                cmd_rec.ovr       = 1'b0;
                cmd_rec.pend_kind = local_on ? lfs_pkg::KIND_ON : lfs_pkg::KIND_OFF;
                cmd_rec.flashes   = 2'd1;
            end
            lfs_pkg::FN_ON: begin
                cmd_rec.pend_kind = lfs_pkg::KIND_ON;
                cmd_rec.ovr       = 1'b1;
            end
            lfs_pkg::FN_OFF: begin
                cmd_rec.pend_kind = lfs_pkg::KIND_OFF;
                cmd_rec.ovr       = 1'b1;
            end
            default: begin
                cmd_rec.pend_kind = lfs_pkg::KIND_FLASH;
                cmd_rec.ovr       = 1'b1;
                cmd_rec.pend_cyc  = lfs_pkg::sat_time(prod_cyc);
                cmd_rec.pend_on   = lfs_pkg::sat_time(prod_on);
                if (rec_cur.cyc_p == '0 && rec_cur.lit) begin
                    cmd_rec.flashes = 2'd2;
                end
            end
        endcase
    end

    assign step_rec = led_step(rec_cur, advance);
    assign rec_next = cmd.apply_cmd ? cmd_rec : step_rec;

    always_comb begin
        lit_mask_next = '0;
        ovr_mask_next = '0;
        for (int i = 0; i < lfs_pkg::MASK_LEDS; i++) begin
            lit_mask_next[i] = led_reg[i].lit;
            ovr_mask_next[i] = led_reg[i].ovr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_tuser;
            count_reg  <= s_tdata[0];
            idx_reg    <= s_tdata[8:1];
            fn_reg     <= s_tdata[16:9];
            ont_reg    <= s_tdata[24:17];
        end
        if (cmd.capture) begin
            status_reg   <= (sts.is_cmd && sts.idx_bad) ? lfs_pkg::STATUS_BAD_IDX
                                                        : lfs_pkg::STATUS_OK;
            lit_mask_reg <= lit_mask_next;
            ovr_mask_reg <= ovr_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dmask_reg  <= 4'd9;
            tscale_reg <= 7'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                lfs_pkg::REG_DEFAULT_ON_MASK: dmask_reg  <= cfg_data[3:0];
                lfs_pkg::REG_TIME_SCALE:      tscale_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lfs_pkg::LED_COUNT; i++) begin
                led_reg[i] <= led_reset(i);
            end
        end else if (cmd.apply_cmd || cmd.step) begin
            led_reg[led_addr] <= rec_next;
        end
    end

    assign m_tuser = status_reg;
    assign m_tdata = {ovr_mask_reg, lit_mask_reg};

endmodule

// ===== rtl/led_flash_sequencer_core.sv =====
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | tuser: action; tdata: count_time, led_index,
//         |     |                    |   function_req, on_time
// m_      | out | m_tvalid/m_tready  | tuser: status; tdata: lit_mask, override_mask
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (register write)
//
// one item at a time: a tick walks load, decode, one step per LED and capture,
// a set-state command adds its apply step, a bad LED index takes only load, decode and capture
// the per-LED pass walks the LEDs through a single shared update unit, one per cycle
// the result sits in an output register, so a new beat is taken while it waits
// a stalled result holds the block in its finish step until the register frees up
// aresetn is synchronous, active low; config writes are taken every cycle
module led_flash_sequencer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,   // [0] action
    input  logic [lfs_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] count_time, [8:1] led_index,
                                                       // [16:9] function_req,
                                                       // [24:17] on_time, [31:25] zero
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tuser,   // [0] status
    output logic [lfs_pkg::M_TDATA_W-1:0]   m_tdata,   // [3:0] lit_mask, [7:4] override_mask
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lfs_pkg::lfs_cmd_t cmd;
    lfs_pkg::lfs_sts_t sts;

    // config registers never back-pressure
    assign cfg_ready = 1'b1;

    // sequencer: walks load, decode, command apply, LED pass and result capture
    lfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // LED state, config registers and the result register
    lfs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/lfs_checker.sv =====
module lfs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic                            m_tuser,
    input logic [lfs_pkg::M_TDATA_W-1:0]   m_tdata
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a result takes at least a decode step after its beat
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind led_flash_sequencer_core lfs_checker u_lfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_led_flash_sequencer_core.sv =====
module tb_led_flash_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::*;

    // one result beat as the block should report it
    typedef struct packed {
        logic       status;
        logic [3:0] lit_mask;
        logic [3:0] ovr_mask;
    } led_report_t;

    // tracks the LED state of the block and checks every result beat against it
    class led_state_tracker;
        lfs_led_t    leds[LED_COUNT];
        logic [3:0]  default_mask;
        logic [6:0]  scale;
        led_report_t reports[$];
        int          mismatches;

        function new();
            for (int i = 0; i < LED_COUNT; i++) begin
                leds[i] = '0;
                leds[i].flashes = 2'd1;
            end
            // the last LED comes out of reset as a 1 s heartbeat
            leds[LED_COUNT-1].on_p  = clip_time(500);
            leds[LED_COUNT-1].cyc_p = clip_time(1000);
            leds[0].lit  = 1'b1;
            default_mask = 4'd9;
            scale        = 7'd10;
            mismatches   = 0;
        endfunction

        function logic [TIME_WIDTH-1:0] clip_time(int unsigned v);
            return (v > int'(TIME_MAX)) ? TIME_MAX : v[TIME_WIDTH-1:0];
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEFAULT_ON_MASK: default_mask = data[3:0];
                REG_TIME_SCALE:      scale = data;
                default: ;
            endcase
        endfunction

        // end of a flash cycle: forced flashes first, then any queued change
        function void end_of_cycle(int i);
            if (leds[i].flashes > 2'd1 && leds[i].cyc_p != '0) begin
                leds[i].lit     = 1'b1;
                leds[i].flashes = leds[i].flashes - 2'd1;
            end else if (leds[i].pend_kind != KIND_NONE) begin
                if (leds[i].pend_kind == KIND_ON) begin
                    leds[i].lit   = 1'b1;
                    leds[i].cyc_p = '0;
                end else if (leds[i].pend_kind == KIND_OFF) begin
                    leds[i].lit   = 1'b0;
                    leds[i].cyc_p = '0;
                end else begin
                    leds[i].lit   = 1'b1;
                    leds[i].cyc_p = leds[i].pend_cyc;
                    leds[i].on_p  = leds[i].pend_on;
                end
                leds[i].pend_kind = KIND_NONE;
            end else if (leds[i].cyc_p != '0) begin
                leds[i].lit = 1'b1;
            end
        endfunction

        // one walk over all LEDs, optionally counting a millisecond
        function void sweep(bit advance);
            for (int i = 0; i < LED_COUNT; i++) begin
                if (leds[i].cyc_p == '0) begin
                    end_of_cycle(i);
                end else begin
                    if (advance)
                        leds[i].ms = leds[i].ms + 1'b1;
                    if (leds[i].ms >= leds[i].cyc_p) begin
                        leds[i].ms = '0;
                        end_of_cycle(i);
                    end
                    if (leds[i].cyc_p != '0 && leds[i].ms == leds[i].on_p)
                        leds[i].lit = 1'b0;
                end
            end
        endfunction

        function void take_item(logic act, logic [S_TDATA_W-1:0] d);
            logic        cnt;
            logic [7:0]  idx;
            logic [7:0]  fn;
            logic [7:0]  ont;
            int          k;
            led_report_t r;
            cnt = d[0];
            idx = d[8:1];
            fn  = d[16:9];
            ont = d[24:17];
            r   = '0;
            r.status = STATUS_OK;
            if (act == ACT_TICK) begin
                sweep(cnt);
            end else if (int'(idx) >= LED_COUNT) begin
                r.status = STATUS_BAD_IDX;
            end else begin
                k = int'(idx);
                if (fn == FN_LOCAL) begin
                    leds[k].ovr       = 1'b0;
                    leds[k].pend_kind = (k < 4 && default_mask[k]) ? KIND_ON : KIND_OFF;
                    leds[k].flashes   = 2'd1;
                end else if (fn == FN_ON) begin
                    leds[k].pend_kind = KIND_ON;
                    leds[k].ovr       = 1'b1;
                end else if (fn == FN_OFF) begin
                    leds[k].pend_kind = KIND_OFF;
                    leds[k].ovr       = 1'b1;
                end else begin
                    leds[k].pend_kind = KIND_FLASH;
                    leds[k].ovr       = 1'b1;
                    leds[k].pend_cyc  = clip_time((int'(fn) + int'(ont)) * int'(scale));
                    leds[k].pend_on   = clip_time(int'(ont) * int'(scale));
                    if (leds[k].cyc_p == '0 && leds[k].lit)
                        leds[k].flashes = 2'd2;
                end
                sweep(1'b0);
            end
            for (int i = 0; i < LED_COUNT && i < 4; i++) begin
                r.lit_mask[i] = leds[i].lit;
                r.ovr_mask[i] = leds[i].ovr;
            end
            reports.push_back(r);
        endfunction

        function void check_beat(logic st, logic [M_TDATA_W-1:0] d);
            led_report_t want;
            if (reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing outstanding: status %0d tdata %h",
                             st, d);
            end else begin
                want = reports.pop_front();
                if (want.status != st || want.lit_mask != d[3:0]
                        || want.ovr_mask != d[7:4]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, lit exp %h got %h, %s",
                                 want.status, st, want.lit_mask, d[3:0],
                                 $sformatf("override exp %h got %h", want.ovr_mask, d[7:4]));
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic                   s_tuser;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   m_tuser;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    led_state_tracker tracker;
    bit               calm = 1'b0;   // no idling on either side while set
    int               results_seen = 0;

    led_flash_sequencer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // handshake monitor: register writes and input beats feed the tracker,
    // result beats are checked against it
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                tracker.take_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                tracker.check_beat(m_tuser, m_tdata);
                results_seen++;
            end
        end
    end

    // result side: random back-pressure plus one long hold so the block backs up
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 200) begin
                held      = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // safety net against a hung handshake
    initial begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    // one input beat, with an occasional idle gap in front of it
    task automatic send_item(logic act, logic cnt, logic [7:0] idx, logic [7:0] fn,
                             logic [7:0] ont);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 21) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, ont, fn, idx, cnt};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering beats and let every outstanding result drain
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.reports.size() != 0) @(posedge aclk);
        // then wait on so the block is back in idle
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic tick(int n);
        repeat (n) send_item(ACT_TICK, 1'b1, 8'h00, 8'h00, 8'h00);
    endtask

    // mostly counting ticks, some set-state commands, a few bad LED indexes;
    // flash times are kept short most of the time so cycles actually complete
    task automatic random_item();
        logic [7:0] idx;
        logic [7:0] fn;
        logic [7:0] ont;
        int         pick;
        if ($urandom_range(0, 99) < 68) begin
            send_item(ACT_TICK, $urandom_range(0, 99) < 90, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
            idx  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, LED_COUNT - 1));
            pick = $urandom_range(0, 9);
            case (pick)
                0:       fn = FN_OFF;
                1:       fn = FN_ON;
                2:       fn = FN_LOCAL;
                3:       fn = 8'($urandom_range(0, 255));
                default: fn = 8'($urandom_range(1, 6));
            endcase
            ont = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 6));
            send_item(ACT_SET_CMD, 1'($urandom_range(0, 1)), idx, fn, ont);
        end
    endtask

    initial begin
        logic [3:0] masks[5];
        logic [6:0] scales[5];
        tracker   = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = ACT_TICK;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DEFAULT_ON_MASK;
        cfg_data  = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: steady changes, bad indexes, extreme flash times
        send_item(ACT_TICK, 1'b0, 8'h00, 8'h00, 8'h00);
        send_item(ACT_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_SET_CMD, 1'b0, 8'd4, FN_ON, 8'h00);
        send_item(ACT_SET_CMD, 1'b1, 8'hFF, FN_OFF, 8'hFF);
        send_item(ACT_SET_CMD, 1'b0, 8'd0, FN_OFF, 8'h00);
        send_item(ACT_SET_CMD, 1'b0, 8'd1, FN_ON, 8'h00);
        send_item(ACT_SET_CMD, 1'b0, 8'd2, FN_LOCAL, 8'h00);
        // heartbeat LED back to local control, queued behind its running cycle
        send_item(ACT_SET_CMD, 1'b0, 8'd3, FN_LOCAL, 8'h00);
        // longest flash times
        send_item(ACT_SET_CMD, 1'b0, 8'd0, 8'hFE, 8'hFF);
        // zero on time
        send_item(ACT_SET_CMD, 1'b0, 8'd2, 8'hFD, 8'h00);
        tick(1);
        drain();

        // 1 ms units: lit steady LED goes flashing (two forced flashes),
        // then an off queued mid-cycle has to stick after the cycle ends
        write_reg(REG_DEFAULT_ON_MASK, 7'd15);
        write_reg(REG_TIME_SCALE, 7'd1);
        send_item(ACT_SET_CMD, 1'b0, 8'd1, 8'h01, 8'h01);
        tick(3);
        send_item(ACT_SET_CMD, 1'b0, 8'd1, FN_OFF, 8'h00);
        tick(4);
        send_item(ACT_SET_CMD, 1'b0, 8'd1, FN_LOCAL, 8'h00);
        drain();

        // zero time scale: a flash with zero cycle period is just steady lit
        write_reg(REG_TIME_SCALE, 7'd0);
        send_item(ACT_SET_CMD, 1'b0, 8'd0, 8'h05, 8'h03);
        tick(2);
        drain();

        // random phases over several register settings, extremes included
        masks  = '{4'd0, 4'd15, 4'd6, 4'($urandom_range(0, 15)), 4'd9};
        scales = '{7'd100, 7'd1, 7'd2, 7'($urandom_range(1, 100)), 7'd1};
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_DEFAULT_ON_MASK, 7'(masks[p]));
            write_reg(REG_TIME_SCALE, scales[p]);
            calm = (p == 2);
            repeat (170) random_item();
            drain();
        end
        calm = 1'b0;

        repeat (16) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lfs_pkg.sv
rtl/lfs_ctrl.sv
rtl/lfs_datapath.sv
rtl/led_flash_sequencer_core.sv
rtl/lfs_checker.sv
sim/tb_led_flash_sequencer_core.sv
